@@ design/assert_macros.svh @@
// assertion macros used by the checker file tfce_checker.sv
// no dependencies; expects clk_i and rst_ni in the scope of use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define TFCE_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("tfce: property violated");

// condition must never be seen at a clock edge outside reset
`define TFCE_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("tfce: forbidden condition seen");

`endif

@@ design/tfce_pkg.sv @@
// shared types, constants and header tables of the command field extractor
// no dependencies
`default_nettype none

package tfce_pkg;

  localparam int unsigned BUFFER_DEPTH_DEF = 1024;
  localparam int unsigned SLOT_LENGTH_DEF  = 16;
  localparam int unsigned SLOT_COUNT       = 3;
  localparam logic [15:0] TIMEOUT_RESET    = 16'd20;

  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam int unsigned FORCED_POS = 12;

  localparam logic [1:0] CMD_DT      = 2'd0;
  localparam logic [1:0] CMD_CD      = 2'd1;
  localparam logic [1:0] CMD_PT      = 2'd2;
  localparam logic [1:0] OUT_SUMMARY = 2'd3;

  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  localparam logic KIND_SLOT    = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  typedef struct packed {
    logic       op;
    logic [7:0] rx_byte;
  } tfce_in_t;

  typedef struct packed {
    logic       kind;
    logic [1:0] command;
    logic [3:0] position;
    logic [7:0] value;
    logic [2:0] found_mask;
    logic       last;
  } tfce_out_t;

  // controller to datapath
  typedef struct packed {
    logic wr_byte;
    logic tick;
    logic frame_init;
    logic pass_next;
    logic ev;
    logic oload;
    logic onext;
    logic clear;
  } tfce_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic frame_hit;
    logic at_end;
    logic pass_stop;
    logic last_cmd;
    logic summary;
  } tfce_stat_t;

  localparam logic [7:0] HDR_TAB [4][16] = '{
    '{"$", "d", "m", "y", "h", "m", "s", 8'h00,
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"$", "c", "u", "t", "d", "o", "w", "n",
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"$", "p", "l", "a", "y", "t", "i", "m",
      "e", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
  };

  function automatic logic [7:0] hdr_char(input logic [1:0] cmd, input logic [3:0] k);
    return HDR_TAB[cmd][k];
  endfunction

  function automatic logic [3:0] hdr_len(input logic [1:0] cmd);
    logic [3:0] len;
    unique case (cmd)
      CMD_DT:  len = 4'd7;
      CMD_CD:  len = 4'd8;
      CMD_PT:  len = 4'd9;
      default: len = 4'd0;
    endcase
    return len;
  endfunction

endpackage

`default_nettype wire

@@ design/tfce_ram.sv @@
// generic single write port ram with registered read
// no dependencies
`default_nettype none

module tfce_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

@@ design/tfce_ctrl.sv @@
// controller state machine: receive, scan passes, result delivery
// depends on tfce_pkg
`default_nettype none

module tfce_ctrl (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  input  wire logic                 in_op_i,
  output logic                      in_stall_o,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  input  wire tfce_pkg::tfce_stat_t stat_i,
  output tfce_pkg::tfce_cmd_t       cmd_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_RD    = 3'd1;
  localparam logic [2:0] S_EV    = 3'd2;
  localparam logic [2:0] S_NEXT  = 3'd3;
  localparam logic [2:0] S_ORD   = 3'd4;
  localparam logic [2:0] S_OLD   = 3'd5;
  localparam logic [2:0] S_OWAIT = 3'd6;

  logic [2:0] state_q, state_d;
  logic       in_xfer;

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = (state_q == S_OWAIT);
  assign in_xfer     = in_valid_i && !in_stall_o;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          if (in_op_i == tfce_pkg::OP_BYTE) begin
            cmd_o.wr_byte = 1'b1;
          end else begin
            cmd_o.tick = 1'b1;
            if (stat_i.frame_hit) begin
              cmd_o.frame_init = 1'b1;
              state_d = S_RD;
            end
          end
        end
      end
      S_RD: begin
        state_d = stat_i.at_end ? S_NEXT : S_EV;
      end
      S_EV: begin
        cmd_o.ev = 1'b1;
        state_d = stat_i.pass_stop ? S_NEXT : S_RD;
      end
      S_NEXT: begin
        if (stat_i.last_cmd) begin
          state_d = S_ORD;
        end else begin
          cmd_o.pass_next = 1'b1;
          state_d = S_RD;
        end
      end
      S_ORD: begin
        state_d = S_OLD;
      end
      S_OLD: begin
        cmd_o.oload = 1'b1;
        state_d = S_OWAIT;
      end
      S_OWAIT: begin
        if (!out_stall_i) begin
          if (stat_i.summary) begin
            cmd_o.clear = 1'b1;
            state_d = S_IDLE;
          end else begin
            cmd_o.onext = 1'b1;
            state_d = S_ORD;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

@@ design/tfce_dp.sv @@
// datapath: frame store, idle timer, header matcher, field copy, slot store
// depends on tfce_pkg and tfce_ram
`default_nettype none

module tfce_dp #(
  parameter int unsigned BUFFER_DEPTH = tfce_pkg::BUFFER_DEPTH_DEF,
  parameter int unsigned SLOT_LENGTH  = tfce_pkg::SLOT_LENGTH_DEF
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire tfce_pkg::tfce_in_t  in_data_i,
  input  wire logic                cfg_we_i,
  input  wire logic [15:0]         cfg_data_i,
  input  wire tfce_pkg::tfce_cmd_t cmd_i,
  output tfce_pkg::tfce_stat_t     stat_o,
  output tfce_pkg::tfce_out_t      out_data_o
);

  localparam int unsigned AW  = $clog2(BUFFER_DEPTH);
  localparam int unsigned IW  = AW + 1;
  localparam int unsigned SD  = tfce_pkg::SLOT_COUNT * SLOT_LENGTH;
  localparam int unsigned SAW = $clog2(SD);
  localparam int unsigned PW  = $clog2(SLOT_LENGTH + 1);

  logic [15:0]   timeout_q;
  logic [15:0]   idle_q;
  logic          dollar_q;
  logic [IW-1:0] wr_q, fill_q, idx_q;
  logic [1:0]    cmd_q, ocmd_q;
  logic [3:0]    mlen_q;
  logic          found_q;
  logic [1:0]    commas_q;
  logic [PW-1:0] pos_q, opos_q;
  logic [2:0]    mask_q;
  logic [SD-1:0] svalid_q;
  tfce_pkg::tfce_out_t out_q;

  logic [AW-1:0]  fr_waddr;
  logic [IW-1:0]  wr_next;
  logic [15:0]    idle_inc;
  logic [7:0]     fr_rd, sl_rd;
  logic [SAW-1:0] sl_waddr, sl_raddr;
  logic           sl_we;
  logic           byte_live;

  assign fr_waddr = (wr_q == IW'(BUFFER_DEPTH)) ? '0 : wr_q[AW-1:0];
  assign wr_next  = {1'b0, fr_waddr} + IW'(1);
  assign idle_inc = (idle_q == 16'hFFFF) ? idle_q : idle_q + 16'd1;

  assign sl_waddr = SAW'(cmd_q) * SAW'(SLOT_LENGTH) + SAW'(pos_q);
  assign sl_raddr = SAW'(ocmd_q) * SAW'(SLOT_LENGTH) + SAW'(opos_q);
  assign byte_live = (fr_rd != 8'h00);
  assign sl_we = cmd_i.ev && byte_live && found_q && (fr_rd != tfce_pkg::CH_COMMA)
                 && (commas_q == 2'd1) && (pos_q < PW'(SLOT_LENGTH));

  tfce_ram #(.WIDTH(8), .DEPTH(BUFFER_DEPTH)) u_frame_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.wr_byte),
    .waddr_i (fr_waddr),
    .wdata_i (in_data_i.rx_byte),
    .raddr_i (idx_q[AW-1:0]),
    .rdata_o (fr_rd)
  );

  tfce_ram #(.WIDTH(8), .DEPTH(SD)) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (sl_we),
    .waddr_i (sl_waddr),
    .wdata_i (fr_rd),
    .raddr_i (sl_raddr),
    .rdata_o (sl_rd)
  );

  always_comb begin
    stat_o.frame_hit = (idle_inc > timeout_q) && dollar_q;
    stat_o.at_end    = (idx_q == fill_q);
    stat_o.pass_stop = !byte_live || (found_q && fr_rd == tfce_pkg::CH_STAR);
    stat_o.last_cmd  = (cmd_q == tfce_pkg::CMD_PT);
    stat_o.summary   = (ocmd_q == tfce_pkg::OUT_SUMMARY);
  end

  assign out_data_o = out_q;

  // receive side and idle timer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= tfce_pkg::TIMEOUT_RESET;
      idle_q    <= '0;
      dollar_q  <= 1'b0;
      wr_q      <= '0;
      fill_q    <= '0;
    end else begin
      if (cfg_we_i) begin
        timeout_q <= cfg_data_i;
      end
      if (cmd_i.wr_byte) begin
        idle_q <= '0;
        wr_q   <= wr_next;
        if (wr_next > fill_q) begin
          fill_q <= wr_next;
        end
        if (in_data_i.rx_byte == tfce_pkg::CH_DOLLAR) begin
          dollar_q <= 1'b1;
        end
      end
      if (cmd_i.tick) begin
        idle_q <= idle_inc;
      end
      if (cmd_i.clear) begin
        wr_q     <= '0;
        fill_q   <= '0;
        dollar_q <= 1'b0;
      end
    end
  end

  // scan passes and delivery counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q    <= '0;
      cmd_q    <= tfce_pkg::CMD_DT;
      mlen_q   <= '0;
      found_q  <= 1'b0;
      commas_q <= '0;
      pos_q    <= '0;
      mask_q   <= '0;
      svalid_q <= '0;
      ocmd_q   <= tfce_pkg::CMD_DT;
      opos_q   <= '0;
    end else begin
      if (cmd_i.frame_init || cmd_i.pass_next) begin
        idx_q    <= '0;
        mlen_q   <= '0;
        found_q  <= 1'b0;
        commas_q <= '0;
        pos_q    <= '0;
      end
      if (cmd_i.frame_init) begin
        cmd_q    <= tfce_pkg::CMD_DT;
        mask_q   <= '0;
        svalid_q <= '0;
        ocmd_q   <= tfce_pkg::CMD_DT;
        opos_q   <= '0;
      end
      if (cmd_i.pass_next) begin
        cmd_q <= cmd_q + 2'd1;
      end
      if (cmd_i.ev) begin
        idx_q <= idx_q + IW'(1);
        if (byte_live) begin
          if (!found_q) begin
            if (fr_rd == tfce_pkg::hdr_char(cmd_q, mlen_q)) begin
              mlen_q <= mlen_q + 4'd1;
              if (mlen_q + 4'd1 == tfce_pkg::hdr_len(cmd_q)) begin
                found_q <= 1'b1;
                mask_q  <= mask_q | (3'd1 << cmd_q);
              end
            end else begin
              mlen_q <= (fr_rd == tfce_pkg::CH_DOLLAR) ? 4'd1 : 4'd0;
            end
          end else if (fr_rd == tfce_pkg::CH_COMMA) begin
            if (commas_q != 2'd2) begin
              commas_q <= commas_q + 2'd1;
            end
            pos_q <= '0;
          end else if (pos_q < PW'(SLOT_LENGTH)) begin
            pos_q <= pos_q + PW'(1);
          end
        end
      end
      if (sl_we) begin
        svalid_q[sl_waddr] <= 1'b1;
      end
      if (cmd_i.onext) begin
        if (opos_q == PW'(SLOT_LENGTH - 1)) begin
          opos_q <= '0;
          ocmd_q <= ocmd_q + 2'd1;
        end else begin
          opos_q <= opos_q + PW'(1);
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.oload) begin
      if (ocmd_q == tfce_pkg::OUT_SUMMARY) begin
        out_q.kind       <= tfce_pkg::KIND_SUMMARY;
        out_q.command    <= '0;
        out_q.position   <= '0;
        out_q.value      <= '0;
        out_q.found_mask <= mask_q;
        out_q.last       <= 1'b1;
      end else begin
        out_q.kind       <= tfce_pkg::KIND_SLOT;
        out_q.command    <= ocmd_q;
        out_q.position   <= opos_q[3:0];
        out_q.found_mask <= '0;
        out_q.last       <= 1'b0;
        if (svalid_q[sl_raddr] && !(ocmd_q == tfce_pkg::CMD_DT &&
            opos_q == PW'(tfce_pkg::FORCED_POS))) begin
          out_q.value <= sl_rd;
        end else begin
          out_q.value <= '0;
        end
      end
    end
  end

endmodule

`default_nettype wire

@@ design/timeout_framed_command_field_extractor.sv @@
// top level of the timeout framed command field extractor
// depends on tfce_pkg, tfce_ctrl, tfce_dp (and tfce_ram through tfce_dp)
//
//   channel | direction | handshake             | payload
//   --------+-----------+-----------------------+---------------------------
//   in      | to block  | in_valid_i/in_stall_o | tfce_in_t: op, rx_byte
//   out     | from block| out_valid_o/out_stall_i| tfce_out_t: kind .. last
//   cfg     | to block  | cfg_we_i              | cfg_data_i: timeout_ticks
//
// a received byte or a tick that ends no frame leaves the controller idle for the next item
// a frame-ending tick runs three scan passes over the filled entries
//   (one frame-store read port, one byte per read/evaluate pair), then
//   49 results, each through the read, load and wait states, plus any downstream stall
// no clearing pass: a fill count marks which frame-store entries are live
// input is stalled from the frame-ending tick until the summary transfer
`default_nettype none

module timeout_framed_command_field_extractor #(
  parameter int unsigned BUFFER_DEPTH = tfce_pkg::BUFFER_DEPTH_DEF,
  parameter int unsigned SLOT_LENGTH  = tfce_pkg::SLOT_LENGTH_DEF
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire tfce_pkg::tfce_in_t  in_data_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output tfce_pkg::tfce_out_t      out_data_o,
  input  wire logic                cfg_we_i,
  input  wire logic [15:0]         cfg_data_i
);

  // command and status between controller and datapath
  tfce_pkg::tfce_cmd_t  cmd;
  tfce_pkg::tfce_stat_t stat;

  // sequencer: idle receive, scan passes per header, result delivery
  tfce_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_op_i     (in_data_i.op),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // frame store, timer, matcher, slot store and result register
  tfce_dp #(
    .BUFFER_DEPTH (BUFFER_DEPTH),
    .SLOT_LENGTH  (SLOT_LENGTH)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (in_data_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .out_data_o (out_data_o)
  );

endmodule

`default_nettype wire

@@ design/tfce_checker.sv @@
// port-level checks of the command field extractor, bound to the top level
// depends on tfce_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module tfce_checker (
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                in_valid_i,
  input wire logic                in_stall_o,
  input wire logic                out_valid_o,
  input wire logic                out_stall_i,
  input wire tfce_pkg::tfce_out_t out_data_o
);

  // a stalled result holds
  `TFCE_ASSERT(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
  // no input transfer while a result is pending
  `TFCE_ASSERT_NEVER(a_no_overlap, in_valid_i && !in_stall_o && out_valid_o)
  // summary is the last result and carries no slot byte
  `TFCE_ASSERT(a_summary, out_valid_o && out_data_o.kind |-> out_data_o.last && out_data_o.value == 8'd0)
  // slot bytes carry no mask and name a real slot
  `TFCE_ASSERT(a_slot, out_valid_o && !out_data_o.kind |-> !out_data_o.last && out_data_o.found_mask == 3'd0 && out_data_o.command != 2'd3)
  // input reopens right after the summary transfer
  `TFCE_ASSERT(a_reopen, out_valid_o && !out_stall_i && out_data_o.kind |=> !in_stall_o)

endmodule

bind timeout_framed_command_field_extractor tfce_checker u_checker (.*);

`default_nettype wire

@@ tb/tb_timeout_framed_command_field_extractor.sv @@
// self-checking testbench for timeout_framed_command_field_extractor
// depends on tfce_pkg and the block itself; a scoreboard class predicts slot bytes and summaries
`default_nettype none

module tb_timeout_framed_command_field_extractor;
  import tfce_pkg::*;

  localparam int unsigned DEPTH    = 1024;
  localparam int unsigned SLOT_LEN = 16;

  // predicts the slot dump of each completed frame and holds it until it leaves the block
  class slot_predictor;
    byte unsigned frame_bytes[DEPTH];
    int unsigned  wr_ptr;
    bit           have_dollar;
    int unsigned  idle_ticks;
    int unsigned  timeout_ticks;
    byte unsigned slots[SLOT_COUNT * SLOT_LEN];
    tfce_out_t    pending_slots[$];
    int unsigned  mismatches;
    int unsigned  results_seen;
    int unsigned  frames_done;
    int unsigned  masks_seen;

    function new();
      foreach (frame_bytes[i]) frame_bytes[i] = 8'h00;
      wr_ptr = 0;
      have_dollar = 1'b0;
      idle_ticks = 0;
      timeout_ticks = TIMEOUT_RESET;
      mismatches = 0;
      results_seen = 0;
      frames_done = 0;
      masks_seen = 0;
    endfunction

    // first-match header search, then capture after the first comma up to the next comma or the star
    function void pull_field(int unsigned slot, string hdr, int unsigned lim,
                             ref bit [2:0] mask);
      int unsigned start;
      int unsigned k;
      int unsigned p;
      int unsigned commas;
      int unsigned pos;
      bit          hit;
      byte unsigned c;
      hit = 1'b0;
      for (start = 0; start + hdr.len() <= lim; start++) begin
        for (k = 0; k < hdr.len(); k++)
          if (frame_bytes[start + k] != hdr[k]) break;
        if (k == hdr.len()) begin
          hit = 1'b1;
          break;
        end
      end
      if (!hit) return;
      mask[slot] = 1'b1;
      commas = 0;
      pos = 0;
      for (p = start + 1; p < lim; p++) begin
        c = frame_bytes[p];
        if (c == CH_COMMA) begin
          if (commas < 2) commas++;
          pos = 0;
        end else begin
          if (commas == 1 && pos < SLOT_LEN) slots[slot * SLOT_LEN + pos] = c;
          if (pos < SLOT_LEN) pos++;
        end
        if (c == CH_STAR) break;
      end
    endfunction

    function void note_transfer(tfce_in_t it);
      int unsigned lim;
      bit [2:0]    mask;
      tfce_out_t   r;
      if (it.op == OP_BYTE) begin
        idle_ticks = 0;
        if (it.rx_byte == CH_DOLLAR) have_dollar = 1'b1;
        if (wr_ptr >= DEPTH) wr_ptr = 0;
        frame_bytes[wr_ptr] = it.rx_byte;
        wr_ptr++;
        return;
      end
      if (idle_ticks < 65535) idle_ticks++;
      if (!(idle_ticks > timeout_ticks && have_dollar)) return;
      foreach (slots[i]) slots[i] = 8'h00;
      lim = DEPTH;
      for (int unsigned i = 0; i < DEPTH; i++)
        if (frame_bytes[i] == 8'h00) begin
          lim = i;
          break;
        end
      mask = '0;
      pull_field(CMD_DT, "$dmyhms", lim, mask);
      pull_field(CMD_CD, "$cutdown", lim, mask);
      pull_field(CMD_PT, "$playtime", lim, mask);
      slots[FORCED_POS] = 8'h00;
      for (int unsigned s = 0; s < SLOT_COUNT; s++)
        for (int unsigned p = 0; p < SLOT_LEN; p++) begin
          r = '0;
          r.kind = KIND_SLOT;
          r.command = s[1:0];
          r.position = p[3:0];
          r.value = slots[s * SLOT_LEN + p];
          pending_slots.push_back(r);
        end
      r = '0;
      r.kind = KIND_SUMMARY;
      r.found_mask = mask;
      r.last = 1'b1;
      pending_slots.push_back(r);
      masks_seen |= (1 << mask);
      frames_done++;
      foreach (frame_bytes[i]) frame_bytes[i] = 8'h00;
      wr_ptr = 0;
      have_dollar = 1'b0;
    endfunction

    function void flag(string what, tfce_out_t exp_r, tfce_out_t got);
      mismatches++;
      if (mismatches <= 10)
        $display({"mismatch %0s: expected kind=%0d cmd=%0d pos=%0d val=%02h mask=%0d ",
                  "last=%0d, got kind=%0d cmd=%0d pos=%0d val=%02h mask=%0d last=%0d"},
                 what, exp_r.kind, exp_r.command, exp_r.position, exp_r.value,
                 exp_r.found_mask, exp_r.last, got.kind, got.command, got.position,
                 got.value, got.found_mask, got.last);
    endfunction

    function void check_result(tfce_out_t got);
      tfce_out_t exp_r;
      results_seen++;
      if (pending_slots.size() == 0) begin
        flag("unexpected result", '0, got);
        return;
      end
      exp_r = pending_slots.pop_front();
      if (got.kind != exp_r.kind) flag("kind", exp_r, got);
      else if (got.command != exp_r.command) flag("command", exp_r, got);
      else if (got.position != exp_r.position) flag("position", exp_r, got);
      else if (got.value != exp_r.value) flag("value", exp_r, got);
      else if (got.found_mask != exp_r.found_mask) flag("found_mask", exp_r, got);
      else if (got.last != exp_r.last) flag("last", exp_r, got);
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  tfce_in_t    in_data_i;
  logic        out_valid_o;
  logic        out_stall_i;
  tfce_out_t   out_data_o;
  logic        cfg_we_i;
  logic [15:0] cfg_data_i;

  slot_predictor sb;
  bit            quiet;        // no idling on either side while set
  int unsigned   items_sent;

  timeout_framed_command_field_extractor i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // generous cap, far above frames with long scans and heavy downstream stalls
  initial begin
    #3000000;
    $display("timeout_framed_command_field_extractor verification failed");
    $finish;
  end

  // random downstream stall, held off during quiet stretches
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      out_stall_i <= !quiet && ($urandom_range(99) < 14);
    end
  end

  // every result transfer is checked against the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_result(out_data_o);
  end

  // one input transfer; valid stays high afterwards, dropped for random idle gaps outside quiet stretches and by drain
  task automatic send_item(input logic op, input logic [7:0] b);
    tfce_in_t it;
    it.op = op;
    it.rx_byte = b;
    if (!quiet && $urandom_range(99) < 14) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= it;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_transfer(it);
    items_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_item(OP_BYTE, s[i]);
  endtask

  task automatic send_ticks(input int unsigned n);
    repeat (n) send_item(OP_TICK, 8'($urandom_range(255)));
  endtask

  // sender pauses until every expected result has left the block
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending_slots.size() != 0) @(posedge clk_i);
    // a byte or a quiet tick may still be in flight with no result behind it
    repeat (8) @(posedge clk_i);
  endtask

  // register write only while the block is idle
  task automatic set_timeout(input logic [15:0] t);
    drain();
    cfg_we_i <= 1'b1;
    cfg_data_i <= t;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.timeout_ticks = t;
  endtask

  // random field text, mostly printable, sometimes with commas, zeros are kept out
  function automatic string rand_field(int unsigned n);
    string s;
    byte unsigned c;
    s = "";
    repeat (n) begin
      case ($urandom_range(9))
        0: c = CH_COMMA;
        1: c = 8'($urandom_range(1, 255));
        default: c = 8'($urandom_range(8'h30, 8'h5A));
      endcase
      s = {s, string'(c)};
    end
    return s;
  endfunction

  // a frame with random headers, fields and noise, followed by ticks past the timeout
  task automatic random_frame();
    string hdrs[3];
    hdrs[0] = "$dmyhms";
    hdrs[1] = "$cutdown";
    hdrs[2] = "$playtime";
    if ($urandom_range(3) == 0) send_text(rand_field($urandom_range(0, 4)));
    for (int h = 0; h < 3; h++) begin
      if ($urandom_range(3) != 0) begin
        send_text(hdrs[$urandom_range(2)]);
        if ($urandom_range(4) != 0) send_text(",");
        send_text(rand_field($urandom_range(0, 20)));
        if ($urandom_range(4) != 0) send_text("*");
        // short idle between sentences, below the timeout most of the time
        if ($urandom_range(4) == 0) send_ticks(1);
      end
    end
    if ($urandom_range(9) == 0) send_item(OP_BYTE, 8'h00);
    if ($urandom_range(5) == 0) send_text("$");
    send_ticks(sb.timeout_ticks + 1 + $urandom_range(2));
  endtask

  initial begin
    sb = new();
    quiet = 1'b0;
    items_sent = 0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    cfg_we_i = 1'b0;
    cfg_data_i = '0;
    rst_ni = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed, with no idling: reset timeout, slot overflow, forced zero, extra commas
    quiet = 1'b1;
    send_text("$dmyhms,0123456789ABCDEFGH*$cutdown,a,b,c*");
    send_item(OP_BYTE, 8'hFF);
    send_ticks(21);
    set_timeout(16'd0);
    quiet = 1'b0;
    // ticks alone never end a frame without a dollar
    send_ticks(2);
    // header cut short by a zero byte, play time with no star
    send_text("$playtime,9*$dmy");
    send_item(OP_BYTE, 8'h00);
    send_text("hms,1*");
    send_ticks(1);
    send_text("$playtime,xyz");
    send_ticks(1);

    // an all-ones timeout holds a frame open through a few ticks
    set_timeout(16'hFFFF);
    send_text("$cutdown,77*");
    send_ticks(3);
    set_timeout(16'd0);
    send_ticks(1);

    // random part: mostly frames with small timeouts, some noise
    while (items_sent < 170) begin
      if ($urandom_range(7) == 0) set_timeout(16'($urandom_range(0, 3)));
      if ($urandom_range(9) == 0) quiet = !quiet;
      if ($urandom_range(3) != 0) begin
        random_frame();
      end else begin
        repeat ($urandom_range(1, 6))
          send_item(1'($urandom_range(1)), 8'($urandom_range(255)));
      end
    end
    quiet = 1'b0;

    drain();
    repeat (50) @(posedge clk_i);
    $display("frames completed: %0d, results checked: %0d, found-mask patterns hit: %b",
             sb.frames_done, sb.results_seen, sb.masks_seen[7:0]);
    $display("covered timeouts 0 to 3, 20 and 65535, slot overflow, extra commas, zero-cut scans");
    if (sb.mismatches == 0 && sb.pending_slots.size() == 0) begin
      $display("timeout_framed_command_field_extractor verification clean");
    end else begin
      $display("mismatches: %0d, results still expected: %0d",
               sb.mismatches, sb.pending_slots.size());
      $display("timeout_framed_command_field_extractor verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
